// ----- rtl/rbfh_pkg.sv -----
// Package for the ray/box near-face hit test core.
// Holds the Q16.16 types, saturation limits and the axis codes; no dependencies.
package rbfh_pkg;

  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  localparam int QuotW    = 48;
  localparam int DivSteps = 49;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_t;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // Clamp a 50-bit signed value to the 32-bit coordinate range.
  function automatic coord_t sat50(input logic signed [49:0] v);
    coord_t r;
    if (v > 50'sd2147483647) r = CoordMax;
    else if (v < -50'sd2147483648) r = CoordMin;
    else r = v[CoordW-1:0];
    return r;
  endfunction

  // Clamp a 33-bit signed sum to the coordinate range.
  function automatic coord_t sat33(input logic signed [CoordW:0] v);
    coord_t r;
    if (v[CoordW] != v[CoordW-1]) r = v[CoordW] ? CoordMin : CoordMax;
    else r = v[CoordW-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/rbfh_if.sv -----
// Valid/ready channel interfaces for the ray/box hit test core.
// Depends on rbfh_pkg for the coordinate and axis types.
interface rbfh_ray_if (input logic clk);
  logic valid;
  logic ready;
  rbfh_pkg::coord_t ray_origin_x, ray_origin_y, ray_origin_z;
  rbfh_pkg::coord_t ray_dir_x, ray_dir_y, ray_dir_z;
  rbfh_pkg::coord_t box_min_x, box_min_y, box_min_z;
  rbfh_pkg::coord_t box_max_x, box_max_y, box_max_z;
  modport source (output valid, ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x,
                  ray_dir_y, ray_dir_z, box_min_x, box_min_y, box_min_z, box_max_x,
                  box_max_y, box_max_z, input ready);
  modport sink (input valid, ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x,
                ray_dir_y, ray_dir_z, box_min_x, box_min_y, box_min_z, box_max_x,
                box_max_y, box_max_z, output ready);
endinterface

interface rbfh_hit_if (input logic clk);
  logic valid;
  logic ready;
  logic hit;
  logic [1:0] hit_axis;
  modport source (output valid, hit, hit_axis, input ready);
  modport sink (input valid, hit, hit_axis, output ready);
endinterface

// ----- rtl/ray_box_face_hit_test_core.sv -----
// Top level of the ray/box near-face hit test: a pipelined divide, multiply and compare.
// Depends on rbfh_pkg and the channel interfaces in rbfh_if.sv.
//
//  channel | direction | carries
//  --------+-----------+---------------------------------------------
//  ray     | in        | origin, direction, box min and max (Q16.16)
//  result  | out       | hit, hit_axis
//
// One transaction is accepted every cycle unless the result channel stalls; the pipeline
// has 55 register stages including the output register.
// The three axes are handled in parallel lanes; after the difference and setup stages
// each lane runs a 49-stage restoring divider (one quotient bit a stage), then
// saturate, multiply, scale-and-add and compare stages.
// Reset clears the valid bits only. A stall on the result freezes the whole
// pipeline (a global enable), so nothing is lost or repeated.
module ray_box_face_hit_test_core (
  input logic clk,
  input logic rst,
  rbfh_ray_if.sink   ray,
  rbfh_hit_if.source result
);

  localparam int Lat = rbfh_pkg::DivSteps + 6;
  localparam int Nw  = 49;   // magnitude width of dividend |d*2^16|
  localparam int Dw  = 32;   // magnitude width of divisor

  typedef struct packed {
    rbfh_pkg::coord_t [2:0] org;
    rbfh_pkg::coord_t [2:0] dir;
    rbfh_pkg::coord_t [2:0] bmn;
    rbfh_pkg::coord_t [2:0] bmx;
  } geo_t;

  typedef struct packed {
    logic [Nw-1:0] rem;     // partial remainder
    logic [Nw-1:0] num;     // dividend bits, shifted out from the top
    logic [Nw-1:0] quo;
    logic [Dw-1:0] den;
    logic          neg;
    logic          skip;
  } div_t;

  logic en;
  logic [Lat-1:0] vld;

  // The pipeline advances unless the output register holds an untaken result.
  assign en = !vld[Lat-1] || result.ready;
  assign ray.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], ray.valid};
    end
  end

  // Geometry delay line alongside the divider.
  geo_t geo [Lat-1];
  geo_t geo_in;
  assign geo_in = '{org: {ray.ray_origin_z, ray.ray_origin_y, ray.ray_origin_x},
                    dir: {ray.ray_dir_z, ray.ray_dir_y, ray.ray_dir_x},
                    bmn: {ray.box_min_z, ray.box_min_y, ray.box_min_x},
                    bmx: {ray.box_max_z, ray.box_max_y, ray.box_max_x}};

  always_ff @(posedge clk) begin
    if (en) begin
      geo[0] <= geo_in;
      for (int s = 1; s < Lat-1; s++) geo[s] <= geo[s-1];
    end
  end

  // Stage 1: pick the near plane and form the saturated difference.
  rbfh_pkg::coord_t d1 [3];
  logic [2:0] zero1;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        d1[a] <= rbfh_pkg::sat33(
          (geo_in.dir[a][31] ? {geo_in.bmx[a][31], geo_in.bmx[a]}
                             : {geo_in.bmn[a][31], geo_in.bmn[a]})
          - {geo_in.org[a][31], geo_in.org[a]});
        zero1[a] <= (geo_in.dir[a] == '0);
      end
    end
  end

  div_t dv [3][rbfh_pkg::DivSteps+1];

  for (genvar a = 0; a < 3; a++) begin : g_lane
    // Stage 2: magnitudes and sign of the quotient set up for the divider.
    logic [Dw:0] dm;
    logic [Dw:0] sm;
    assign dm = d1[a][31] ? -{1'b1, d1[a]} : {1'b0, d1[a]};
    assign sm = geo[0].dir[a][31] ? -{1'b1, geo[0].dir[a]} : {1'b0, geo[0].dir[a]};

    always_ff @(posedge clk) begin
      if (en) begin
        dv[a][0].rem  <= '0;
        dv[a][0].num  <= {1'b0, dm[Dw-1:0], 16'd0};
        dv[a][0].quo  <= '0;
        dv[a][0].den  <= sm[Dw-1:0];
        dv[a][0].neg  <= d1[a][31] ^ geo[0].dir[a][31];
        dv[a][0].skip <= zero1[a];
      end
    end

    // Divider stages: one quotient bit per stage, truncated toward zero.
    for (genvar s = 0; s < rbfh_pkg::DivSteps; s++) begin : g_step
      logic [Nw:0] trial;
      logic [Nw-1:0] shifted;
      assign shifted = {dv[a][s].rem[Nw-2:0], dv[a][s].num[Nw-1]};
      assign trial = {1'b0, shifted} - {{(Nw-Dw+1){1'b0}}, dv[a][s].den};
      always_ff @(posedge clk) begin
        if (en) begin
          dv[a][s+1].rem  <= trial[Nw] ? shifted : trial[Nw-1:0];
          dv[a][s+1].num  <= {dv[a][s].num[Nw-2:0], 1'b0};
          dv[a][s+1].quo  <= {dv[a][s].quo[Nw-2:0], !trial[Nw]};
          dv[a][s+1].den  <= dv[a][s].den;
          dv[a][s+1].neg  <= dv[a][s].neg;
          dv[a][s+1].skip <= dv[a][s].skip;
        end
      end
    end
  end

  // Saturate t and keep it only when positive.
  localparam int Gq = rbfh_pkg::DivSteps + 2;   // geo index read by the product stage
  rbfh_pkg::coord_t t_r [3];
  logic [2:0] tok;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        logic [Nw-1:0] q;
        logic pos_big;
        q = dv[a][rbfh_pkg::DivSteps].quo;
        pos_big = (q[Nw-1:31] != '0);
        if (dv[a][rbfh_pkg::DivSteps].neg) begin
          t_r[a] <= '0;
          tok[a] <= 1'b0;
        end else begin
          t_r[a] <= pos_big ? rbfh_pkg::CoordMax : q[31:0];
          tok[a] <= !dv[a][rbfh_pkg::DivSteps].skip && (q != '0);
        end
      end
    end
  end

  // Products dir_o * t for the two other axes of each lane.
  logic signed [63:0] prod [3][2];
  logic [2:0] tok2;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 2; j++) begin
          prod[a][j] <= geo[Gq].dir[(a+j+1)%3] * t_r[a];
        end
        tok2[a] <= tok[a];
      end
    end
  end

  // Scale by 2^-16 truncated toward zero, saturate, add to the origin.
  rbfh_pkg::coord_t pt [3][2];
  logic [2:0] tok3;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 2; j++) begin
          logic signed [63:0] b;
          logic signed [49:0] m;
          rbfh_pkg::coord_t ms;
          b = prod[a][j];
          if (b[63]) b = b + 64'sd65535;
          m = {{2{b[63]}}, b[63:16]};
          ms = rbfh_pkg::sat50(m);
          pt[a][j] <= rbfh_pkg::sat33({geo[Gq+1].org[(a+j+1)%3][31],
                                       geo[Gq+1].org[(a+j+1)%3]} + {ms[31], ms});
        end
        tok3[a] <= tok2[a];
      end
    end
  end

  // Strict inside tests, first passing axis wins, into the output register.
  logic hit_r;
  logic [1:0] axis_r;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [2:0] pass;
      for (int a = 0; a < 3; a++) begin
        pass[a] = tok3[a];
        for (int j = 0; j < 2; j++) begin
          if (!(geo[Gq+2].bmn[(a+j+1)%3] < pt[a][j] &&
                pt[a][j] < geo[Gq+2].bmx[(a+j+1)%3])) pass[a] = 1'b0;
        end
      end
      hit_r <= |pass;
      priority if (pass[0]) axis_r <= rbfh_pkg::AXIS_X;
      else if (pass[1])     axis_r <= rbfh_pkg::AXIS_Y;
      else if (pass[2])     axis_r <= rbfh_pkg::AXIS_Z;
      else                  axis_r <= rbfh_pkg::AXIS_NONE;
    end
  end

  assign result.valid    = vld[Lat-1];
  assign result.hit      = hit_r;
  assign result.hit_axis = axis_r;

endmodule

// ----- dv/ray_box_face_hit_test_core_tb.sv -----
// Testbench for the ray/box near-face hit test core.
// Depends on rbfh_pkg, the channel interfaces in rbfh_if.sv and the core itself.
`timescale 1ns / 1ps

module ray_box_face_hit_test_core_tb;

  localparam int ResetCycles = 9;
  localparam int Latency = 54;
  localparam int StallLimit = 20000;
  localparam int RandomItems = 1100;

  typedef struct {
    rbfh_pkg::coord_t org[3];
    rbfh_pkg::coord_t dir[3];
    rbfh_pkg::coord_t bmn[3];
    rbfh_pkg::coord_t bmx[3];
  } ray_box_t;

  typedef struct {
    logic hit;
    rbfh_pkg::axis_t axis;
  } face_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rbfh_ray_if ray (clk);
  rbfh_hit_if result (clk);

  ray_box_face_hit_test_core i_dut (
    .clk(clk),
    .rst(rst),
    .ray(ray.sink),
    .result(result.source)
  );

  always #5 clk = ~clk;

  face_hit_t expected_hits[$];
  int errors = 0;
  int sent = 0;
  int hits_seen = 0;
  int received = 0;
  int idle_count = 0;
  bit drive_quiet = 1'b0;
  bit sink_quiet = 1'b0;
  bit hold_off = 1'b0;

  // Saturate a wide signed value to the coordinate range.
  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Predict which near face, if any, the ray enters first.
  function automatic face_hit_t predict_face_hit(input ray_box_t rb);
    face_hit_t r;
    longint plane, d, t, m, p, dk;
    int o;
    bit in_face;
    r.hit = 1'b0;
    r.axis = rbfh_pkg::AXIS_NONE;
    for (int a = 0; a < 3; a++) begin
      if (r.hit) break;
      dk = rb.dir[a];
      if (dk == 0) continue;
      plane = (dk > 0) ? longint'(rb.bmn[a]) : longint'(rb.bmx[a]);
      d = clamp32(plane - longint'(rb.org[a]));
      t = clamp32((d * 65536) / dk);
      if (t <= 0) continue;
      in_face = 1'b1;
      for (int j = 1; j <= 2; j++) begin
        o = (a + j) % 3;
        m = clamp32((longint'(rb.dir[o]) * t) / 65536);
        p = clamp32(longint'(rb.org[o]) + m);
        if (!(longint'(rb.bmn[o]) < p && p < longint'(rb.bmx[o]))) in_face = 1'b0;
      end
      if (in_face) begin
        r.hit = 1'b1;
        r.axis = rbfh_pkg::axis_t'(a + 1);
      end
    end
    return r;
  endfunction

  // Offer one ray/box pair and wait until it is accepted.
  task automatic send_ray_box(input ray_box_t rb);
    while (!drive_quiet && $urandom_range(99) < 9) begin
      ray.valid <= 1'b0;
      @(posedge clk);
    end
    ray.valid <= 1'b1;
    ray.ray_origin_x <= rb.org[0];
    ray.ray_origin_y <= rb.org[1];
    ray.ray_origin_z <= rb.org[2];
    ray.ray_dir_x <= rb.dir[0];
    ray.ray_dir_y <= rb.dir[1];
    ray.ray_dir_z <= rb.dir[2];
    ray.box_min_x <= rb.bmn[0];
    ray.box_min_y <= rb.bmn[1];
    ray.box_min_z <= rb.bmn[2];
    ray.box_max_x <= rb.bmx[0];
    ray.box_max_y <= rb.bmx[1];
    ray.box_max_z <= rb.bmx[2];
    @(posedge clk);
    while (!ray.ready) @(posedge clk);
    expected_hits.push_back(predict_face_hit(rb));
    sent++;
  endtask

  function automatic rbfh_pkg::coord_t rand_coord();
    case ($urandom_range(5))
      0: return rbfh_pkg::CoordMax;
      1: return rbfh_pkg::CoordMin;
      2: return rbfh_pkg::coord_t'(0);
      3: return rbfh_pkg::coord_t'($urandom);
      default: return rbfh_pkg::coord_t'($urandom_range(20 << 16))
                      - rbfh_pkg::coord_t'(10 << 16);
    endcase
  endfunction

  // A box of modest size with a ray aimed roughly at it.
  function automatic ray_box_t aimed_ray_box();
    ray_box_t rb;
    rbfh_pkg::coord_t c, h;
    for (int k = 0; k < 3; k++) begin
      c = rbfh_pkg::coord_t'($urandom_range(40 << 16)) - rbfh_pkg::coord_t'(20 << 16);
      h = rbfh_pkg::coord_t'($urandom_range(8 << 16));
      rb.bmn[k] = c - h;
      rb.bmx[k] = c + h;
      rb.org[k] = rbfh_pkg::coord_t'($urandom_range(80 << 16))
                  - rbfh_pkg::coord_t'(40 << 16);
      rb.dir[k] = (c - rb.org[k]) >>> $urandom_range(4);
      if ($urandom_range(7) == 0) rb.dir[k] = 0;
    end
    return rb;
  endfunction

  function automatic ray_box_t noise_ray_box();
    ray_box_t rb;
    for (int k = 0; k < 3; k++) begin
      rb.org[k] = rand_coord();
      rb.dir[k] = rand_coord();
      rb.bmn[k] = rand_coord();
      rb.bmx[k] = rand_coord();
    end
    return rb;
  endfunction

  function automatic ray_box_t unit_box(input rbfh_pkg::coord_t ox,
                                        input rbfh_pkg::coord_t dx,
                                        input rbfh_pkg::coord_t dy,
                                        input rbfh_pkg::coord_t dz);
    ray_box_t rb;
    for (int k = 0; k < 3; k++) begin
      rb.bmn[k] = -(rbfh_pkg::coord_t'(1) <<< 16);
      rb.bmx[k] = rbfh_pkg::coord_t'(1) <<< 16;
      rb.org[k] = 0;
    end
    rb.org[0] = ox;
    rb.dir[0] = dx;
    rb.dir[1] = dy;
    rb.dir[2] = dz;
    return rb;
  endfunction

  // Stop offering and wait until every expected result has come back.
  task automatic wait_drained();
    ray.valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  // Directed cases: a near face on each axis, skipped axes, edges, inverted boxes, extremes.
  task automatic test_directed();
    ray_box_t rb;
    send_ray_box(unit_box(-(5 << 16), 1 << 16, 0, 0));
    send_ray_box(unit_box(5 << 16, -(1 << 16), 0, 0));
    rb = unit_box(0, 0, 0, 0);
    rb.org[1] = -(5 << 16);
    rb.dir[1] = 1 << 16;
    send_ray_box(rb);
    rb = unit_box(0, 0, 0, 0);
    rb.org[2] = 5 << 16;
    rb.dir[2] = -(1 << 16);
    send_ray_box(rb);
    send_ray_box(unit_box(0, 0, 0, 0));
    send_ray_box(unit_box(5 << 16, 1 << 16, 0, 0));
    rb = unit_box(-(5 << 16), 1 << 16, 0, 0);
    rb.org[1] = 1 << 16;
    send_ray_box(rb);
    rb = unit_box(-(5 << 16), 1 << 16, 0, 0);
    rb.bmn[1] = 1 << 16;
    rb.bmx[1] = -(1 << 16);
    send_ray_box(rb);
    rb = unit_box(-(5 << 16), 1 << 16, 0, 0);
    rb.bmn[1] = 0;
    rb.bmx[1] = 0;
    send_ray_box(rb);
    send_ray_box(unit_box(rbfh_pkg::CoordMin, 1, 0, 0));
    send_ray_box(unit_box(rbfh_pkg::CoordMin, rbfh_pkg::CoordMax, rbfh_pkg::CoordMax,
                          rbfh_pkg::CoordMin));
    send_ray_box(unit_box(rbfh_pkg::CoordMax, rbfh_pkg::CoordMin, 1, -1));
    rb = unit_box(rbfh_pkg::CoordMin, rbfh_pkg::CoordMax, 0, 0);
    rb.bmn[0] = rbfh_pkg::CoordMax;
    rb.bmx[0] = rbfh_pkg::CoordMax;
    send_ray_box(rb);
    for (int k = 0; k < 3; k++) begin
      rb.org[k] = rbfh_pkg::CoordMax;
      rb.dir[k] = rbfh_pkg::CoordMin;
      rb.bmn[k] = rbfh_pkg::CoordMin;
      rb.bmx[k] = rbfh_pkg::CoordMax;
    end
    send_ray_box(rb);
    for (int k = 0; k < 3; k++) begin
      rb.org[k] = -1;
      rb.dir[k] = -1;
      rb.bmn[k] = -1;
      rb.bmx[k] = -1;
    end
    send_ray_box(rb);
    for (int i = 0; i < 6; i++) send_ray_box(noise_ray_box());
  endtask

  // Random traffic, mostly aimed rays, with a stall-free stretch.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      drive_quiet = (i >= count / 2 && i < count / 2 + 150);
      sink_quiet = drive_quiet;
      send_ray_box(($urandom_range(99) < 75) ? aimed_ray_box() : noise_ray_box());
    end
    drive_quiet = 1'b0;
    sink_quiet = 1'b0;
  endtask

  // Receiver holds off long enough for the pipeline to fill and back up.
  task automatic test_back_pressure();
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++) send_ray_box(aimed_ray_box());
    wait_drained();
    for (int i = 0; i < 20; i++) send_ray_box(aimed_ray_box());
  endtask

  // Sink side: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_off) begin
      result.ready <= 1'b0;
      if (idle_count == 400) begin
        hold_off <= 1'b0;
        idle_count <= 0;
      end else begin
        idle_count <= idle_count + 1;
      end
    end else begin
      result.ready <= sink_quiet || ($urandom_range(99) >= 9);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    face_hit_t e;
    if (!rst && result.valid && result.ready) begin
      received++;
      if (expected_hits.size() == 0) begin
        $error("unexpected result transaction: hit %0d axis %0d",
               result.hit, result.hit_axis);
        errors++;
      end else begin
        e = expected_hits.pop_front();
        if (result.hit !== e.hit) begin
          $error("hit: expected %0d, actual %0d", e.hit, result.hit);
          errors++;
        end
        if (result.hit_axis !== e.axis) begin
          $error("hit_axis: expected %0d, actual %0d", e.axis, result.hit_axis);
          errors++;
        end
        if (e.hit) hits_seen++;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((ray.valid && ray.ready) || (result.valid && result.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("ray_box_face_hit_test_core_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ray.valid = 1'b0;
    ray.ray_origin_x = '0;
    ray.ray_origin_y = '0;
    ray.ray_origin_z = '0;
    ray.ray_dir_x = '0;
    ray.ray_dir_y = '0;
    ray.ray_dir_z = '0;
    ray.box_min_x = '0;
    ray.box_min_y = '0;
    ray.box_min_z = '0;
    ray.box_max_x = '0;
    ray.box_max_y = '0;
    ray.box_max_z = '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(RandomItems);
    test_back_pressure();
    wait_drained();
    repeat (Latency * 2) @(posedge clk);
    $display("Sent %0d ray/box tests, checked %0d results, %0d of them face hits.",
             sent, received, hits_seen);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("ray_box_face_hit_test_core_tb: done, clean");
    end else begin
      $display("ray_box_face_hit_test_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rbfh_pkg.sv
rtl/rbfh_if.sv
rtl/ray_box_face_hit_test_core.sv
dv/ray_box_face_hit_test_core_tb.sv
